/* sv/pfsb_pkg.sv */
// ----------------------------------------------------------------------------
// pfsb_pkg: shared types and constants of the flag and stopwatch bank
// Opcodes, beat field widths and the fixed-point constants of the
// microsecond to millisecond conversion.
// ----------------------------------------------------------------------------
package pfsb_pkg;

   localparam int OPCODE_W   = 3;
   localparam int CHANNEL_W  = 3;
   localparam int INTERVAL_W = 16;
   localparam int COUNTER_W  = 8;
   localparam int PRESCALE_W = 4;
   localparam int US_W       = 32;
   localparam int MS_W       = 16;

   // partial time (counter << 15) >> 3 fits in 20 bits
   localparam int PARTIAL_W  = 20;

   localparam logic [PRESCALE_W-1:0] PRESCALE_RESET = 4'd6;

   // q = (n * RECIP) >> RECIP_SHIFT equals n / 1000 for any 32-bit n
   localparam int RECIP_W     = 29;
   localparam int RECIP_SHIFT = 38;
   localparam logic [RECIP_W-1:0] MS_RECIP = 29'd274877907;
   localparam int PROD_W      = US_W + RECIP_W;
   localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

   typedef enum logic [OPCODE_W-1:0] {
      OP_TICK        = 3'd0,
      OP_TASK_START  = 3'd1,
      OP_TASK_STOP   = 3'd2,
      OP_TASK_DONE   = 3'd3,
      OP_TASK_QUERY  = 3'd4,
      OP_WATCH_START = 3'd5,
      OP_WATCH_STOP  = 3'd6,
      OP_WATCH_READ  = 3'd7
   } op_type;

endpackage

/* sv/pfsb_req_if.sv */
// ----------------------------------------------------------------------------
// pfsb_req_if: request channel of the flag and stopwatch bank
// Valid/ready channel carrying one opcode beat.
// ----------------------------------------------------------------------------
interface pfsb_req_if;
   import pfsb_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [OPCODE_W-1:0]   opcode;
   logic [CHANNEL_W-1:0]  channel;
   logic [INTERVAL_W-1:0] interval;
   logic [COUNTER_W-1:0]  counter_now;

   modport source (output valid, opcode, channel, interval, counter_now, input ready);
   modport sink   (input valid, opcode, channel, interval, counter_now, output ready);

endinterface

/* sv/pfsb_rsp_if.sv */
// ----------------------------------------------------------------------------
// pfsb_rsp_if: response channel of the flag and stopwatch bank
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
interface pfsb_rsp_if;
   import pfsb_pkg::*;

   logic            valid;
   logic            ready;
   logic            task_due;
   logic [US_W-1:0] elapsed_us;
   logic [MS_W-1:0] elapsed_ms;

   modport source (output valid, task_due, elapsed_us, elapsed_ms, input ready);
   modport sink   (input valid, task_due, elapsed_us, elapsed_ms, output ready);

endinterface

/* sv/periodic_flag_and_stopwatch_bank_top.sv */
// ----------------------------------------------------------------------------
// periodic_flag_and_stopwatch_bank_top: periodic task flags and stopwatches
// Bank of periodic task channels and stopwatch channels driven by opcode
// beats, with a three-register pipeline: input register, state update,
// millisecond conversion.
//
//   channel   direction  beat contents
//   req_if    in         opcode, channel, interval, counter_now
//   rsp_if    out        task_due, elapsed_us, elapsed_ms
//   csr_*     in         prescaler_log2 write, no read-back
//
// One beat per cycle is accepted while no stall holds the pipeline; a beat
// then passes the second register and the result register. Bank state is
// updated as a beat leaves the input register. A stalled response holds the
// pipeline; free stages still fill, so up to three beats are in flight. The
// synchronous reset clears all channels and sets the prescaler to default.
// ----------------------------------------------------------------------------
module periodic_flag_and_stopwatch_bank_top #(
   parameter int TASK_CHANNELS  = 8,
   parameter int WATCH_CHANNELS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   pfsb_req_if.sink                        req_if,
   pfsb_rsp_if.source                      rsp_if,
   input  logic                            csr_we,
   input  logic [pfsb_pkg::PRESCALE_W-1:0] csr_wdata
);
   import pfsb_pkg::*;

   localparam int TIDX_W = (TASK_CHANNELS > 1) ? $clog2(TASK_CHANNELS) : 1;
   localparam int WIDX_W = (WATCH_CHANNELS > 1) ? $clog2(WATCH_CHANNELS) : 1;

   // pipeline control
   logic adv1, adv2, adv3;

   // configuration
   logic [PRESCALE_W-1:0] prescale_ff;

   // input register
   logic                  s1_valid_ff;
   op_type                s1_op_ff;
   logic [CHANNEL_W-1:0]  s1_chan_ff;
   logic [INTERVAL_W-1:0] s1_ival_ff;
   logic [COUNTER_W-1:0]  s1_cnt_ff;

   // bank state
   logic                  task_on_ff     [TASK_CHANNELS];
   logic                  task_on_in     [TASK_CHANNELS];
   logic                  task_flag_ff   [TASK_CHANNELS];
   logic                  task_flag_in   [TASK_CHANNELS];
   logic [INTERVAL_W-1:0] tick_count_ff  [TASK_CHANNELS];
   logic [INTERVAL_W-1:0] tick_count_in  [TASK_CHANNELS];
   logic [INTERVAL_W-1:0] task_period_ff [TASK_CHANNELS];
   logic [INTERVAL_W-1:0] task_period_in [TASK_CHANNELS];
   logic                  watch_on_ff    [WATCH_CHANNELS];
   logic                  watch_on_in    [WATCH_CHANNELS];
   logic [US_W-1:0]       watch_us_ff    [WATCH_CHANNELS];
   logic [US_W-1:0]       watch_us_in    [WATCH_CHANNELS];

   // stage 1 logic
   logic                  s1_fire;
   logic                  tvalid, wvalid;
   logic [TIDX_W-1:0]     tidx;
   logic [WIDX_W-1:0]     widx;
   logic [PARTIAL_W-1:0]  partial;
   logic [US_W-1:0]       tick_inc;
   logic [INTERVAL_W-1:0] count_inc;
   logic [US_W-1:0]       stored_us;
   logic signed [US_W:0]  signed_sum;
   logic                  read_hit;

   // second register
   logic                  s2_valid_ff;
   logic                  s2_due_ff, s2_due_in;
   logic [US_W-1:0]       s2_us_ff, s2_us_in;
   logic [US_W-1:0]       s2_mag_ff, s2_mag_in;
   logic                  s2_neg_ff, s2_neg_in;
   logic                  s2_read_ff;

   // stage 2 logic
   logic [PROD_W-1:0]     product;
   logic [QUOT_W-1:0]     quotient;
   logic [MS_W-1:0]       ms_in;

   // result register
   logic                  out_valid_ff;
   logic                  out_due_ff;
   logic [US_W-1:0]       out_us_ff;
   logic [MS_W-1:0]       out_ms_ff;

   assign adv3 = !out_valid_ff || rsp_if.ready;
   assign adv2 = !s2_valid_ff || adv3;
   assign adv1 = !s1_valid_ff || adv2;
   assign req_if.ready = adv1;
   assign s1_fire = s1_valid_ff && adv2;

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff <= PRESCALE_RESET;
      end else if (csr_we) begin
         prescale_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv1) begin
         s1_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1 && req_if.valid) begin
         s1_op_ff   <= op_type'(req_if.opcode);
         s1_chan_ff <= req_if.channel;
         s1_ival_ff <= req_if.interval;
         s1_cnt_ff  <= req_if.counter_now;
      end
   end

   assign tvalid = (32'(s1_chan_ff) < TASK_CHANNELS);
   assign wvalid = (32'(s1_chan_ff) < WATCH_CHANNELS);
   assign tidx   = TIDX_W'(s1_chan_ff);
   assign widx   = WIDX_W'(s1_chan_ff);

   assign partial  = PARTIAL_W'((US_W'(s1_cnt_ff) << prescale_ff) >> 3);
   assign tick_inc = (US_W'(256) << prescale_ff) >> 3;

   // next bank state
   always_comb begin
      count_inc = '0;
      for (int i = 0; i < TASK_CHANNELS; i++) begin
         task_on_in[i]     = task_on_ff[i];
         task_flag_in[i]   = task_flag_ff[i];
         tick_count_in[i]  = tick_count_ff[i];
         task_period_in[i] = task_period_ff[i];
      end
      for (int i = 0; i < WATCH_CHANNELS; i++) begin
         watch_on_in[i] = watch_on_ff[i];
         watch_us_in[i] = watch_us_ff[i];
      end
      if (s1_fire) begin
         case (s1_op_ff)
            OP_TICK: begin
               for (int i = 0; i < TASK_CHANNELS; i++) begin
                  count_inc = tick_count_ff[i] + 1'b1;
                  if (task_on_ff[i]) begin
                     if (count_inc == task_period_ff[i]) begin
                        tick_count_in[i] = '0;
                        task_flag_in[i]  = 1'b1;
                     end else begin
                        tick_count_in[i] = count_inc;
                     end
                  end
               end
               for (int i = 0; i < WATCH_CHANNELS; i++) begin
                  if (watch_on_ff[i]) begin
                     watch_us_in[i] = watch_us_ff[i] + tick_inc;
                  end
               end
            end
            OP_TASK_START: begin
               if (tvalid) begin
                  task_period_in[tidx] = s1_ival_ff;
                  task_on_in[tidx]     = 1'b1;
                  tick_count_in[tidx]  = '0;
               end
            end
            OP_TASK_STOP: begin
               if (tvalid) begin
                  task_on_in[tidx]    = 1'b0;
                  tick_count_in[tidx] = '0;
               end
            end
            OP_TASK_DONE: begin
               if (tvalid) begin
                  task_flag_in[tidx] = 1'b0;
               end
            end
            OP_WATCH_START: begin
               if (wvalid) begin
                  watch_us_in[widx] = '0 - US_W'(partial);
                  watch_on_in[widx] = 1'b1;
               end
            end
            OP_WATCH_STOP: begin
               if (wvalid) begin
                  watch_on_in[widx] = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TASK_CHANNELS; i++) begin
            task_on_ff[i]     <= 1'b0;
            task_flag_ff[i]   <= 1'b0;
            tick_count_ff[i]  <= '0;
            task_period_ff[i] <= '0;
         end
         for (int i = 0; i < WATCH_CHANNELS; i++) begin
            watch_on_ff[i] <= 1'b0;
            watch_us_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < TASK_CHANNELS; i++) begin
            task_on_ff[i]     <= task_on_in[i];
            task_flag_ff[i]   <= task_flag_in[i];
            tick_count_ff[i]  <= tick_count_in[i];
            task_period_ff[i] <= task_period_in[i];
         end
         for (int i = 0; i < WATCH_CHANNELS; i++) begin
            watch_on_ff[i] <= watch_on_in[i];
            watch_us_ff[i] <= watch_us_in[i];
         end
      end
   end

   // read path: sum and its magnitude for the millisecond divide
   always_comb begin
      read_hit   = (s1_op_ff == OP_WATCH_READ) && wvalid;
      stored_us  = wvalid ? watch_us_ff[widx] : '0;
      signed_sum = $signed({stored_us[US_W-1], stored_us})
                 + $signed({{(US_W + 1 - PARTIAL_W){1'b0}}, partial});
      s2_neg_in  = signed_sum[US_W];
      s2_mag_in  = s2_neg_in ? US_W'(-signed_sum) : signed_sum[US_W-1:0];
      s2_us_in   = read_hit ? (stored_us + US_W'(partial)) : '0;
      s2_due_in  = tvalid && task_flag_in[tidx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv2) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         s2_due_ff  <= s2_due_in;
         s2_us_ff   <= s2_us_in;
         s2_mag_ff  <= s2_mag_in;
         s2_neg_ff  <= s2_neg_in;
         s2_read_ff <= read_hit;
      end
   end

   // divide by 1000 through reciprocal multiply
   always_comb begin
      product  = PROD_W'(s2_mag_ff) * PROD_W'(MS_RECIP);
      quotient = product[PROD_W-1:RECIP_SHIFT];
      if (!s2_read_ff) begin
         ms_in = '0;
      end else if (s2_neg_ff) begin
         ms_in = '0 - quotient[MS_W-1:0];
      end else begin
         ms_in = quotient[MS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv3) begin
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv3 && s2_valid_ff) begin
         out_due_ff <= s2_due_ff;
         out_us_ff  <= s2_us_ff;
         out_ms_ff  <= ms_in;
      end
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.task_due   = out_due_ff;
   assign rsp_if.elapsed_us = out_us_ff;
   assign rsp_if.elapsed_ms = out_ms_ff;

endmodule

/* sim/periodic_flag_and_stopwatch_bank_top_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// periodic_flag_and_stopwatch_bank_top_test: self-checking bench for the bank
// Opcode beats from a pending queue are driven in random bursts while the
// result side stalls on a pattern of its own and now and then holds off long
// enough to back up the pipeline. Every accepted beat goes through an
// untimed model of the task and stopwatch channels, and the result beats are
// compared in order, field by field. The run covers directed corner cases, a
// tick run at the largest prescaler, and random traffic under several
// prescaler settings, the extremes among them.
// ----------------------------------------------------------------------------
module periodic_flag_and_stopwatch_bank_top_test;
   import pfsb_pkg::*;

   localparam int NUM_CHANNELS = 8;
   localparam int PHASE_CMDS   = 160;
   localparam int TICK_RUN     = 80;
   localparam int IDLE_LIMIT   = 1000;
   localparam int HOLD_CYCLES  = 90;
   localparam int HOLD_SPACING = 450;
   localparam int DRAIN_CYCLES = 10;
   localparam logic [7:0] STALL_MASK = 8'b1011_0110;

   typedef struct packed {
      op_type                opcode;
      logic [CHANNEL_W-1:0]  channel;
      logic [INTERVAL_W-1:0] interval;
      logic [COUNTER_W-1:0]  counter_now;
   } timer_cmd_type;

   typedef struct packed {
      logic            task_due;
      logic [US_W-1:0] elapsed_us;
      logic [MS_W-1:0] elapsed_ms;
   } timer_result_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [PRESCALE_W-1:0] csr_wdata;

   pfsb_req_if req_bus ();
   pfsb_rsp_if rsp_bus ();

   periodic_flag_and_stopwatch_bank_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // channel model
   logic [PRESCALE_W-1:0] prescale_q;
   logic                  task_run      [NUM_CHANNELS];
   logic                  task_due_flag [NUM_CHANNELS];
   logic [INTERVAL_W-1:0] task_ticks    [NUM_CHANNELS];
   logic [INTERVAL_W-1:0] task_reload   [NUM_CHANNELS];
   logic                  watch_run     [NUM_CHANNELS];
   logic [US_W-1:0]       watch_time    [NUM_CHANNELS];

   timer_cmd_type    pending_cmds[$];
   timer_result_type expected_results[$];

   int n_sent       = 0;
   int n_accepted   = 0;
   int n_checked    = 0;
   int n_errors     = 0;
   int n_settings   = 0;
   int n_due        = 0;
   int n_reads      = 0;
   int burst_left   = 1;
   int gap_left     = 0;
   int hold_left    = 0;
   int next_hold_at = 250;
   int idle_cycles  = 0;

   logic [7:0]       stall_cycle = '0;
   logic             req_fire    = 1'b0;
   timer_cmd_type    drive_cmd;
   timer_cmd_type    seen_cmd;
   timer_result_type want_res;

   function automatic timer_result_type bank_step(timer_cmd_type c);
      timer_result_type r;
      logic [US_W-1:0]  part;
      logic [US_W-1:0]  step_us;
      longint signed    total;
      longint signed    msec;
      int               i;
      r       = '0;
      part    = US_W'((64'(c.counter_now) << prescale_q) >> 3);
      step_us = US_W'((64'd256 << prescale_q) >> 3);
      case (c.opcode)
         OP_TICK: begin
            for (i = 0; i < NUM_CHANNELS; i++) begin
               if (task_run[i]) begin
                  task_ticks[i] = task_ticks[i] + 16'd1;
                  if (task_ticks[i] == task_reload[i]) begin
                     task_ticks[i]    = '0;
                     task_due_flag[i] = 1'b1;
                  end
               end
               if (watch_run[i])
                  watch_time[i] = watch_time[i] + step_us;
            end
         end
         OP_TASK_START: begin
            task_reload[c.channel] = c.interval;
            task_run[c.channel]    = 1'b1;
            task_ticks[c.channel]  = '0;
         end
         OP_TASK_STOP: begin
            task_run[c.channel]   = 1'b0;
            task_ticks[c.channel] = '0;
         end
         OP_TASK_DONE: task_due_flag[c.channel] = 1'b0;
         OP_TASK_QUERY: ;
         OP_WATCH_START: begin
            watch_time[c.channel] = '0 - part;
            watch_run[c.channel]  = 1'b1;
         end
         OP_WATCH_STOP: watch_run[c.channel] = 1'b0;
         OP_WATCH_READ: begin
            r.elapsed_us = watch_time[c.channel] + part;
            // signed sum, not wrapped, divided toward zero
            total        = longint'(signed'(watch_time[c.channel])) + longint'(part);
            msec         = total / 1000;
            r.elapsed_ms = msec[MS_W-1:0];
         end
      endcase
      r.task_due = task_due_flag[c.channel];
      return r;
   endfunction

   task automatic queue_cmd(op_type op, int unsigned ch, int unsigned ival, int unsigned cnt);
      timer_cmd_type c;
      c.opcode      = op;
      c.channel     = CHANNEL_W'(ch);
      c.interval    = INTERVAL_W'(ival);
      c.counter_now = COUNTER_W'(cnt);
      pending_cmds.push_back(c);
      n_sent++;
   endtask

   task automatic queue_random_cmds(int count);
      int          sel;
      op_type      op;
      int unsigned ival;
      int unsigned cnt;
      repeat (count) begin
         sel = $urandom_range(0, 99);
         if (sel < 30)      op = OP_TICK;
         else if (sel < 42) op = OP_TASK_START;
         else if (sel < 48) op = OP_TASK_STOP;
         else if (sel < 58) op = OP_TASK_DONE;
         else if (sel < 66) op = OP_TASK_QUERY;
         else if (sel < 76) op = OP_WATCH_START;
         else if (sel < 82) op = OP_WATCH_STOP;
         else               op = OP_WATCH_READ;
         // mostly short intervals so that due flags come up often
         case ($urandom_range(0, 9))
            0:       ival = 0;
            1, 2:    ival = $urandom_range(0, 65535);
            3:       ival = 65535;
            default: ival = $urandom_range(1, 6);
         endcase
         case ($urandom_range(0, 7))
            0:       cnt = 0;
            1:       cnt = 255;
            default: cnt = $urandom_range(0, 255);
         endcase
         queue_cmd(op, $urandom_range(0, NUM_CHANNELS - 1), ival, cnt);
      end
   endtask

   task automatic wait_drained();
      while (n_accepted != n_sent || expected_results.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_prescaler(logic [PRESCALE_W-1:0] value);
      wait_drained();
      csr_we    = 1'b1;
      csr_wdata = value;
      @(negedge clock);
      csr_we    = 1'b0;
      n_settings++;
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // driver: bursts of random length with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_fire) begin
         if (gap_left > 0) begin
            gap_left--;
            req_bus.valid <= 1'b0;
         end else if (pending_cmds.size() > 0) begin
            drive_cmd = pending_cmds.pop_front();
            req_bus.valid       <= 1'b1;
            req_bus.opcode      <= drive_cmd.opcode;
            req_bus.channel     <= drive_cmd.channel;
            req_bus.interval    <= drive_cmd.interval;
            req_bus.counter_now <= drive_cmd.counter_now;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left--;
            end
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // receiver: rotating stall pattern plus occasional long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         stall_cycle = stall_cycle + 8'd1;
         if (hold_left == 0 && n_checked >= next_hold_at) begin
            hold_left    = HOLD_CYCLES;
            next_hold_at = next_hold_at + HOLD_SPACING;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (stall_cycle[7:6])
               2'd0:    rsp_bus.ready <= 1'b1;
               2'd1:    rsp_bus.ready <= ($urandom_range(0, 9) > 3);
               2'd2:    rsp_bus.ready <= STALL_MASK[stall_cycle[2:0]];
               default: rsp_bus.ready <= ($urandom_range(0, 9) > 0);
            endcase
         end
      end
   end

   // monitor: predict on accepted requests, check accepted results
   always @(posedge clock) begin : monitor
      int k;
      req_fire <= req_bus.valid && req_bus.ready && !reset;
      if (reset) begin
         prescale_q = PRESCALE_RESET;
         for (k = 0; k < NUM_CHANNELS; k++) begin
            task_run[k]      = 1'b0;
            task_due_flag[k] = 1'b0;
            task_ticks[k]    = '0;
            task_reload[k]   = '0;
            watch_run[k]     = 1'b0;
            watch_time[k]    = '0;
         end
      end else begin
         if (csr_we)
            prescale_q = csr_wdata;
         if (req_bus.valid && req_bus.ready) begin
            seen_cmd.opcode      = op_type'(req_bus.opcode);
            seen_cmd.channel     = req_bus.channel;
            seen_cmd.interval    = req_bus.interval;
            seen_cmd.counter_now = req_bus.counter_now;
            if (seen_cmd.opcode == OP_WATCH_READ)
               n_reads++;
            expected_results.push_back(bank_step(seen_cmd));
            n_accepted++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_results.size() == 0) begin
               n_errors++;
               $display("%0t: result beat with none expected: due %0d us %0d ms %0d",
                        $time, rsp_bus.task_due, rsp_bus.elapsed_us, rsp_bus.elapsed_ms);
            end else begin
               want_res = expected_results.pop_front();
               n_checked++;
               if (want_res.task_due)
                  n_due++;
               if (rsp_bus.task_due !== want_res.task_due) begin
                  n_errors++;
                  $display("%0t: task_due expected %0d actual %0d",
                           $time, want_res.task_due, rsp_bus.task_due);
               end
               if (rsp_bus.elapsed_us !== want_res.elapsed_us) begin
                  n_errors++;
                  $display("%0t: elapsed_us expected %0d actual %0d",
                           $time, want_res.elapsed_us, rsp_bus.elapsed_us);
               end
               if (rsp_bus.elapsed_ms !== want_res.elapsed_ms) begin
                  n_errors++;
                  $display("%0t: elapsed_ms expected %0d actual %0d",
                           $time, want_res.elapsed_ms, rsp_bus.elapsed_ms);
               end
            end
         end
      end
   end

   // watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles = 0;
      else
         idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_wdata           = '0;
      req_bus.valid       = 1'b0;
      req_bus.opcode      = '0;
      req_bus.channel     = '0;
      req_bus.interval    = '0;
      req_bus.counter_now = '0;
      rsp_bus.ready       = 1'b0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // directed cases at the reset prescaler
      queue_cmd(OP_WATCH_READ, 0, 0, 255);
      queue_cmd(OP_TASK_START, 0, 1, 0);
      queue_cmd(OP_TASK_START, 7, 65535, 255);
      queue_cmd(OP_TASK_START, 3, 0, 0);
      queue_cmd(OP_WATCH_START, 0, 0, 255);
      queue_cmd(OP_WATCH_START, 7, 0, 0);
      queue_cmd(OP_TICK, 0, 0, 0);
      queue_cmd(OP_TASK_QUERY, 0, 0, 0);
      // stop keeps the due flag
      queue_cmd(OP_TASK_STOP, 0, 0, 0);
      queue_cmd(OP_TICK, 5, 65535, 255);
      queue_cmd(OP_TASK_QUERY, 0, 0, 0);
      queue_cmd(OP_TASK_DONE, 0, 0, 0);
      queue_cmd(OP_TICK, 0, 0, 0);
      queue_cmd(OP_WATCH_READ, 0, 0, 0);
      queue_cmd(OP_WATCH_READ, 7, 0, 255);
      queue_cmd(OP_WATCH_STOP, 7, 0, 0);
      queue_cmd(OP_TICK, 0, 0, 0);
      // read of a stopped stopwatch
      queue_cmd(OP_WATCH_READ, 7, 0, 128);
      queue_cmd(OP_TASK_DONE, 7, 0, 0);
      queue_cmd(OP_TASK_QUERY, 3, 0, 0);
      // negative stored time gives a negative millisecond quotient
      queue_cmd(OP_WATCH_START, 5, 0, 200);
      queue_cmd(OP_WATCH_READ, 5, 0, 0);
      queue_cmd(OP_TASK_START, 1, 65535, 0);

      write_prescaler(4'd0);
      queue_random_cmds(PHASE_CMDS);

      write_prescaler(4'd10);
      queue_random_cmds(PHASE_CMDS);

      // prescaler above ten, tick run with ignored fields
      write_prescaler(4'd15);
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         queue_cmd(OP_TASK_STOP, i, 0, 0);
         queue_cmd(OP_TASK_DONE, i, 0, 0);
         queue_cmd(OP_WATCH_STOP, i, 0, 0);
      end
      queue_cmd(OP_TASK_START, 2, 0, 0);
      queue_cmd(OP_TASK_START, 4, 65535, 0);
      queue_cmd(OP_TASK_START, 6, 2, 0);
      queue_cmd(OP_WATCH_START, 1, 0, 255);
      queue_cmd(OP_WATCH_START, 6, 0, 1);
      repeat (TICK_RUN)
         queue_cmd(OP_TICK, $urandom_range(0, 7), $urandom_range(0, 65535),
                   $urandom_range(0, 255));
      queue_cmd(OP_TASK_QUERY, 2, 0, 0);
      queue_cmd(OP_TASK_QUERY, 4, 0, 0);
      queue_cmd(OP_TICK, 0, 0, 0);
      queue_cmd(OP_TASK_QUERY, 2, 0, 0);
      queue_cmd(OP_TASK_QUERY, 6, 0, 0);
      queue_cmd(OP_WATCH_READ, 1, 0, 255);
      queue_cmd(OP_WATCH_READ, 6, 0, 0);
      queue_random_cmds(PHASE_CMDS);

      write_prescaler(4'($urandom_range(1, 9)));
      queue_random_cmds(PHASE_CMDS);

      write_prescaler(4'($urandom_range(0, 15)));
      queue_random_cmds(PHASE_CMDS);

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("checked %0d result beats across %0d prescaler writes and a %0d-tick run",
               n_checked, n_settings, TICK_RUN);
      $display("%0d beats showed a due flag, %0d were stopwatch reads, %0d mismatches",
               n_due, n_reads, n_errors);
      if (n_errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

/* filelist.f */
sv/pfsb_pkg.sv
sv/pfsb_req_if.sv
sv/pfsb_rsp_if.sv
sv/periodic_flag_and_stopwatch_bank_top.sv
sim/periodic_flag_and_stopwatch_bank_top_test.sv
